/* rtl/core/qpr_pkg.sv */
// Shared constants for the quaternion point rotation pipeline.
// No dependencies; used by every module of the block.
`default_nettype none

package qpr_pkg;

    // Three coordinates per point, a 3x3 rotation matrix per quaternion
    localparam int NUM_AXES = 3;
    localparam int NUM_COEF = NUM_AXES * NUM_AXES;

endpackage

`default_nettype wire

/* rtl/core/qpr_coef.sv */
// Quaternion component products and rotation matrix coefficients (two stages).
// Depends on qpr_pkg.
`default_nettype none

module qpr_coef #(
    parameter int QUAT_WIDTH  = 16,
    parameter int COORD_WIDTH = 24,
    parameter int CW          = 2 * QUAT_WIDTH + 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_w,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_x,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_y,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_z,
    input  wire logic signed [COORD_WIDTH-1:0] pt_in [qpr_pkg::NUM_AXES],
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [CW-1:0]               coef [qpr_pkg::NUM_COEF],
    output logic signed [COORD_WIDTH-1:0]      pt_out [qpr_pkg::NUM_AXES]
);

    localparam int PW = 2 * QUAT_WIDTH;

    // product slots
    localparam int P_WW = 0;
    localparam int P_XX = 1;
    localparam int P_YY = 2;
    localparam int P_ZZ = 3;
    localparam int P_XY = 4;
    localparam int P_WZ = 5;
    localparam int P_XZ = 6;
    localparam int P_WY = 7;
    localparam int P_YZ = 8;
    localparam int P_WX = 9;
    localparam int NUM_PROD = 10;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic signed [PW-1:0]          prod_reg [NUM_PROD];
    logic signed [PW-1:0]          prod_next [NUM_PROD];
    logic signed [COORD_WIDTH-1:0] s1_pt_reg [qpr_pkg::NUM_AXES];

    logic                          s2_valid_reg;
    logic                          s2_valid_next;
    logic signed [CW-1:0]          coef_reg [qpr_pkg::NUM_COEF];
    logic signed [CW-1:0]          coef_next [qpr_pkg::NUM_COEF];
    logic signed [COORD_WIDTH-1:0] s2_pt_reg [qpr_pkg::NUM_AXES];

    logic s1_en;
    logic s2_en;

    // stage enables: a stage loads when empty or when it drains downstream
    assign s2_en    = !s2_valid_reg || out_ready;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    assign s1_valid_next = s1_en ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_en ? s1_valid_reg : s2_valid_reg;

    // stage 1: ten component products, exact at 2*QUAT_WIDTH bits
    always_comb
    begin
        prod_next[P_WW] = PW'(quat_w) * PW'(quat_w);
        prod_next[P_XX] = PW'(quat_x) * PW'(quat_x);
        prod_next[P_YY] = PW'(quat_y) * PW'(quat_y);
        prod_next[P_ZZ] = PW'(quat_z) * PW'(quat_z);
        prod_next[P_XY] = PW'(quat_x) * PW'(quat_y);
        prod_next[P_WZ] = PW'(quat_w) * PW'(quat_z);
        prod_next[P_XZ] = PW'(quat_x) * PW'(quat_z);
        prod_next[P_WY] = PW'(quat_w) * PW'(quat_y);
        prod_next[P_YZ] = PW'(quat_y) * PW'(quat_z);
        prod_next[P_WX] = PW'(quat_w) * PW'(quat_x);
    end

    // stage 2: matrix coefficients, row major
    always_comb
    begin
        coef_next[0] = CW'(prod_reg[P_WW]) + CW'(prod_reg[P_XX])
                     - CW'(prod_reg[P_YY]) - CW'(prod_reg[P_ZZ]);
        coef_next[1] = (CW'(prod_reg[P_XY]) - CW'(prod_reg[P_WZ])) <<< 1;
        coef_next[2] = (CW'(prod_reg[P_XZ]) + CW'(prod_reg[P_WY])) <<< 1;
        coef_next[3] = (CW'(prod_reg[P_XY]) + CW'(prod_reg[P_WZ])) <<< 1;
        coef_next[4] = CW'(prod_reg[P_WW]) - CW'(prod_reg[P_XX])
                     + CW'(prod_reg[P_YY]) - CW'(prod_reg[P_ZZ]);
        coef_next[5] = (CW'(prod_reg[P_YZ]) - CW'(prod_reg[P_WX])) <<< 1;
        coef_next[6] = (CW'(prod_reg[P_XZ]) - CW'(prod_reg[P_WY])) <<< 1;
        coef_next[7] = (CW'(prod_reg[P_YZ]) + CW'(prod_reg[P_WX])) <<< 1;
        coef_next[8] = CW'(prod_reg[P_WW]) - CW'(prod_reg[P_XX])
                     - CW'(prod_reg[P_YY]) + CW'(prod_reg[P_ZZ]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid)
        begin
            prod_reg  <= prod_next;
            s1_pt_reg <= pt_in;
        end
        if (s2_en && s1_valid_reg)
        begin
            coef_reg  <= coef_next;
            s2_pt_reg <= s1_pt_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign coef      = coef_reg;
    assign pt_out    = s2_pt_reg;

endmodule

`default_nettype wire

/* rtl/core/qpr_mac.sv */
// Matrix-vector multiply: split partial products, row sums, exact accumulate
// with the rounding half added (three stages). Depends on qpr_pkg.
`default_nettype none

module qpr_mac #(
    parameter int QUAT_WIDTH  = 16,
    parameter int COORD_WIDTH = 24,
    parameter int CW          = 2 * QUAT_WIDTH + 2,
    parameter int AW          = CW + COORD_WIDTH + 2
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [CW-1:0]          coef [qpr_pkg::NUM_COEF],
    input  wire logic signed [COORD_WIDTH-1:0] pt [qpr_pkg::NUM_AXES],
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [AW-1:0]               acc [qpr_pkg::NUM_AXES]
);

    // coefficient split: low H bits unsigned, remaining bits signed
    localparam int H   = QUAT_WIDTH + 1;
    localparam int HW  = CW - H;
    localparam int LW  = H + 1;
    localparam int LPW = LW + COORD_WIDTH;
    localparam int HPW = HW + COORD_WIDTH;
    localparam int LSW = LPW + 2;
    localparam int HSW = HPW + 2;
    localparam int F   = 2 * (QUAT_WIDTH - 1);
    localparam logic signed [AW-1:0] HALF = AW'(1) << (F - 1);

    logic                 a_valid_reg;
    logic                 a_valid_next;
    logic signed [LPW-1:0] mlo_reg [qpr_pkg::NUM_COEF];
    logic signed [LPW-1:0] mlo_next [qpr_pkg::NUM_COEF];
    logic signed [HPW-1:0] mhi_reg [qpr_pkg::NUM_COEF];
    logic signed [HPW-1:0] mhi_next [qpr_pkg::NUM_COEF];

    logic                 b_valid_reg;
    logic                 b_valid_next;
    logic signed [LSW-1:0] slo_reg [qpr_pkg::NUM_AXES];
    logic signed [LSW-1:0] slo_next [qpr_pkg::NUM_AXES];
    logic signed [HSW-1:0] shi_reg [qpr_pkg::NUM_AXES];
    logic signed [HSW-1:0] shi_next [qpr_pkg::NUM_AXES];

    logic                 c_valid_reg;
    logic                 c_valid_next;
    logic signed [AW-1:0] acc_reg [qpr_pkg::NUM_AXES];
    logic signed [AW-1:0] acc_next [qpr_pkg::NUM_AXES];

    logic a_en;
    logic b_en;
    logic c_en;

    assign c_en     = !c_valid_reg || out_ready;
    assign b_en     = !b_valid_reg || c_en;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;

    assign a_valid_next = a_en ? in_valid : a_valid_reg;
    assign b_valid_next = b_en ? a_valid_reg : b_valid_reg;
    assign c_valid_next = c_en ? b_valid_reg : c_valid_reg;

    // stage A: two partial products per coefficient
    always_comb
    begin
        for (int r = 0; r < qpr_pkg::NUM_AXES; r++)
        begin
            for (int c = 0; c < qpr_pkg::NUM_AXES; c++)
            begin
                mlo_next[r * qpr_pkg::NUM_AXES + c] =
                    LPW'($signed({1'b0, coef[r * qpr_pkg::NUM_AXES + c][H-1:0]}))
                    * LPW'(pt[c]);
                mhi_next[r * qpr_pkg::NUM_AXES + c] =
                    HPW'($signed(coef[r * qpr_pkg::NUM_AXES + c][CW-1:H]))
                    * HPW'(pt[c]);
            end
        end
    end

    // stage B: row sums of low and high partials
    always_comb
    begin
        for (int r = 0; r < qpr_pkg::NUM_AXES; r++)
        begin
            slo_next[r] = LSW'(mlo_reg[r * qpr_pkg::NUM_AXES])
                        + LSW'(mlo_reg[r * qpr_pkg::NUM_AXES + 1])
                        + LSW'(mlo_reg[r * qpr_pkg::NUM_AXES + 2]);
            shi_next[r] = HSW'(mhi_reg[r * qpr_pkg::NUM_AXES])
                        + HSW'(mhi_reg[r * qpr_pkg::NUM_AXES + 1])
                        + HSW'(mhi_reg[r * qpr_pkg::NUM_AXES + 2]);
        end
    end

    // stage C: recombine halves, add one half LSB of the result
    always_comb
    begin
        for (int r = 0; r < qpr_pkg::NUM_AXES; r++)
        begin
            acc_next[r] = (AW'(shi_reg[r]) <<< H) + AW'(slo_reg[r]) + HALF;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (a_en && in_valid)
        begin
            mlo_reg <= mlo_next;
            mhi_reg <= mhi_next;
        end
        if (b_en && a_valid_reg)
        begin
            slo_reg <= slo_next;
            shi_reg <= shi_next;
        end
        if (c_en && b_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign acc       = acc_reg;

endmodule

`default_nettype wire

/* rtl/core/qpr_round.sv */
// Drop fraction bits, saturate to the coordinate range, output register.
// Depends on qpr_pkg.
`default_nettype none

module qpr_round #(
    parameter int QUAT_WIDTH  = 16,
    parameter int COORD_WIDTH = 24,
    parameter int AW          = 2 * QUAT_WIDTH + COORD_WIDTH + 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [AW-1:0]    acc [qpr_pkg::NUM_AXES],
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [COORD_WIDTH-1:0]       rotated [qpr_pkg::NUM_AXES],
    output logic                         clipped
);

    localparam int F  = 2 * (QUAT_WIDTH - 1);
    localparam int RW = AW - F;
    localparam logic signed [RW-1:0] MAX_V =
        {{(RW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [RW-1:0] MIN_V = ~MAX_V;

    logic                   valid_reg;
    logic                   valid_next;
    logic [COORD_WIDTH-1:0] rot_reg [qpr_pkg::NUM_AXES];
    logic [COORD_WIDTH-1:0] rot_next [qpr_pkg::NUM_AXES];
    logic                   clip_reg;
    logic                   clip_next;
    logic signed [RW-1:0]   rnd [qpr_pkg::NUM_AXES];
    logic                   en;

    assign en         = !valid_reg || out_ready;
    assign in_ready   = en;
    assign valid_next = en ? in_valid : valid_reg;

    // floor after the half was added; clamp each axis
    always_comb
    begin
        clip_next = 1'b0;
        for (int r = 0; r < qpr_pkg::NUM_AXES; r++)
        begin
            rnd[r] = acc[r][AW-1:F];
            if (rnd[r] > MAX_V)
            begin
                rot_next[r] = MAX_V[COORD_WIDTH-1:0];
                clip_next   = 1'b1;
            end
            else if (rnd[r] < MIN_V)
            begin
                rot_next[r] = MIN_V[COORD_WIDTH-1:0];
                clip_next   = 1'b1;
            end
            else
            begin
                rot_next[r] = rnd[r][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            rot_reg  <= rot_next;
            clip_reg <= clip_next;
        end
    end

    assign out_valid = valid_reg;
    assign rotated   = rot_reg;
    assign clipped   = clip_reg;

endmodule

`default_nettype wire

/* rtl/core/quaternion_point_rotation.sv */
// Quaternion point rotation: registered in qpr_coef, qpr_mac, then qpr_round.
// Throughput one point per cycle while the output is not stalled; every stage
// has its own valid bit and loads whenever it is empty or its content moves on,
// so bubbles close up on a stall. The throughput bound is the single register
// stage per step of the datapath. Reset clears only the valid bits; no state
// survives between points. Depends on qpr_pkg, qpr_coef, qpr_mac, qpr_round.
`default_nettype none

module quaternion_point_rotation #(
    parameter int COORD_WIDTH = 24,
    parameter int QUAT_WIDTH  = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_w,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_x,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_y,
    input  wire logic signed [QUAT_WIDTH-1:0]  quat_z,
    input  wire logic signed [COORD_WIDTH-1:0] point_x,
    input  wire logic signed [COORD_WIDTH-1:0] point_y,
    input  wire logic signed [COORD_WIDTH-1:0] point_z,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0]      rotated_x,
    output logic signed [COORD_WIDTH-1:0]      rotated_y,
    output logic signed [COORD_WIDTH-1:0]      rotated_z,
    output logic                               clipped
);

    localparam int CW = 2 * QUAT_WIDTH + 2;
    localparam int AW = CW + COORD_WIDTH + 2;
    localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] C_MIN = ~C_MAX;

    logic signed [COORD_WIDTH-1:0] pt_in [qpr_pkg::NUM_AXES];
    logic signed [COORD_WIDTH-1:0] coef_pt [qpr_pkg::NUM_AXES];
    logic signed [CW-1:0]          coef [qpr_pkg::NUM_COEF];
    logic                          coef_valid;
    logic                          mac_ready;
    logic signed [AW-1:0]          acc [qpr_pkg::NUM_AXES];
    logic                          acc_valid;
    logic                          rnd_ready;
    logic [COORD_WIDTH-1:0]        rotated [qpr_pkg::NUM_AXES];

    assign pt_in[0] = point_x;
    assign pt_in[1] = point_y;
    assign pt_in[2] = point_z;

    // products and matrix coefficients
    qpr_coef #(
        .QUAT_WIDTH  (QUAT_WIDTH),
        .COORD_WIDTH (COORD_WIDTH),
        .CW          (CW)
    ) u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .pt_in     (pt_in),
        .out_valid (coef_valid),
        .out_ready (mac_ready),
        .coef      (coef),
        .pt_out    (coef_pt)
    );

    // matrix times point
    qpr_mac #(
        .QUAT_WIDTH  (QUAT_WIDTH),
        .COORD_WIDTH (COORD_WIDTH),
        .CW          (CW),
        .AW          (AW)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (coef_valid),
        .in_ready  (mac_ready),
        .coef      (coef),
        .pt        (coef_pt),
        .out_valid (acc_valid),
        .out_ready (rnd_ready),
        .acc       (acc)
    );

    // rounding, saturation, output register
    qpr_round #(
        .QUAT_WIDTH  (QUAT_WIDTH),
        .COORD_WIDTH (COORD_WIDTH),
        .AW          (AW)
    ) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc_valid),
        .in_ready  (rnd_ready),
        .acc       (acc),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rotated   (rotated),
        .clipped   (clipped)
    );

    assign rotated_x = $signed(rotated[0]);
    assign rotated_y = $signed(rotated[1]);
    assign rotated_z = $signed(rotated[2]);

`ifndef SYNTH
    // a saturated result has at least one coordinate at a range bound
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |->
            (rotated[0] == C_MAX) || (rotated[0] == C_MIN) ||
            (rotated[1] == C_MAX) || (rotated[1] == C_MIN) ||
            (rotated[2] == C_MAX) || (rotated[2] == C_MIN))
        else $error("clipped set with no coordinate at a bound");

    // the input side only backs up when the whole pipe is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while the pipeline has room");

    // a new result needs an item in the accumulate stage the cycle before
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(acc_valid))
        else $error("result appeared without an item upstream");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

// Self-checking testbench for quaternion_point_rotation: a directed stimulus table,
// then random points, checked against hand values or an exact wide-integer rotation predictor.
// Depends only on the RTL top module quaternion_point_rotation.
module testbench;

    localparam int COORD_W      = 24;
    localparam int QUAT_W       = 16;
    localparam int FRAC_BITS    = 2 * (QUAT_W - 1);
    localparam int RAND_ITEMS   = 1100;
    localparam int NUM_PHASES   = 3;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 4000;

    // Exact accumulator, wide enough for any sum of weighted coordinates
    typedef logic signed [95:0] acc_t;

    localparam acc_t TWO        = acc_t'(2);
    localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_BITS - 1);
    localparam acc_t COORD_MAX  = (acc_t'(1) <<< (COORD_W - 1)) - acc_t'(1);
    localparam acc_t COORD_MIN  = -COORD_MAX - acc_t'(1);

    typedef struct {
        logic signed [QUAT_W-1:0]  w, x, y, z;
        logic signed [COORD_W-1:0] px, py, pz;
    } point_item_t;

    typedef struct {
        logic signed [COORD_W-1:0] rx, ry, rz;
        logic                      clip;
    } rotation_t;

    typedef struct {
        point_item_t item;
        bit          typed;
        rotation_t   want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [QUAT_W-1:0]  quat_w, quat_x, quat_y, quat_z;
    logic signed [COORD_W-1:0] point_x, point_y, point_z;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [COORD_W-1:0] rotated_x, rotated_y, rotated_z;
    logic clipped;

    rotation_t   expected_rotations[$];
    stim_row_t   directed_rows[$];
    int          error_count = 0;
    int          stall_cycles = 0;
    int unsigned src_idle_pct = 17;
    int unsigned sink_stall_pct = 53;

    always #6 clk = ~clk;

    quaternion_point_rotation #(
        .COORD_WIDTH (COORD_W),
        .QUAT_WIDTH  (QUAT_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rotated_x (rotated_x),
        .rotated_y (rotated_y),
        .rotated_z (rotated_z),
        .clipped   (clipped)
    );

    // qa * qb * p, exact
    function automatic acc_t weighted(input logic signed [QUAT_W-1:0] qa,
                                      input logic signed [QUAT_W-1:0] qb,
                                      input logic signed [COORD_W-1:0] p);
        return acc_t'(qa) * acc_t'(qb) * acc_t'(p);
    endfunction

    // Round half up, drop the fraction bits, clamp to the coordinate range
    function automatic logic signed [COORD_W-1:0] round_sat(input acc_t acc,
                                                            inout logic clip);
        acc_t r;
        r = (acc + ROUND_HALF) >>> FRAC_BITS;
        if (r > COORD_MAX)
        begin
            clip = 1'b1;
            r = COORD_MAX;
        end
        else if (r < COORD_MIN)
        begin
            clip = 1'b1;
            r = COORD_MIN;
        end
        return r[COORD_W-1:0];
    endfunction

    // Rotation matrix expanded from the quaternion, applied to the point
    function automatic rotation_t rotate_point(input point_item_t it);
        rotation_t res;
        acc_t      ax, ay, az;
        logic      clip;
        ax = weighted(it.w, it.w, it.px) + weighted(it.x, it.x, it.px)
           - weighted(it.y, it.y, it.px) - weighted(it.z, it.z, it.px)
           + TWO * (weighted(it.x, it.y, it.py) - weighted(it.w, it.z, it.py))
           + TWO * (weighted(it.x, it.z, it.pz) + weighted(it.w, it.y, it.pz));
        ay = TWO * (weighted(it.x, it.y, it.px) + weighted(it.w, it.z, it.px))
           + weighted(it.w, it.w, it.py) - weighted(it.x, it.x, it.py)
           + weighted(it.y, it.y, it.py) - weighted(it.z, it.z, it.py)
           + TWO * (weighted(it.y, it.z, it.pz) - weighted(it.w, it.x, it.pz));
        az = TWO * (weighted(it.x, it.z, it.px) - weighted(it.w, it.y, it.px))
           + TWO * (weighted(it.y, it.z, it.py) + weighted(it.w, it.x, it.py))
           + weighted(it.w, it.w, it.pz) - weighted(it.x, it.x, it.pz)
           - weighted(it.y, it.y, it.pz) + weighted(it.z, it.z, it.pz);
        clip = 1'b0;
        res.rx = round_sat(ax, clip);
        res.ry = round_sat(ay, clip);
        res.rz = round_sat(az, clip);
        res.clip = clip;
        return res;
    endfunction

    function automatic stim_row_t dir_row(input int w, input int x, input int y,
                                          input int z, input int px, input int py,
                                          input int pz, input bit typed,
                                          input int rx, input int ry, input int rz,
                                          input bit clip);
        stim_row_t r;
        r.item.w  = QUAT_W'(w);
        r.item.x  = QUAT_W'(x);
        r.item.y  = QUAT_W'(y);
        r.item.z  = QUAT_W'(z);
        r.item.px = COORD_W'(px);
        r.item.py = COORD_W'(py);
        r.item.pz = COORD_W'(pz);
        r.typed     = typed;
        r.want.rx   = COORD_W'(rx);
        r.want.ry   = COORD_W'(ry);
        r.want.rz   = COORD_W'(rz);
        r.want.clip = clip;
        return r;
    endfunction

    // Present one point, with a random idle gap ahead; returns at its transfer
    task automatic drive_point(input point_item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_w   <= it.w;
        quat_x   <= it.x;
        quat_y   <= it.y;
        quat_z   <= it.z;
        point_x  <= it.px;
        point_y  <= it.py;
        point_z  <= it.pz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Output side: check each transfer, randomize ready, watch for a hang
    always @(posedge clk)
    begin : result_side
        rotation_t want;
        if (out_valid && out_ready)
        begin
            if (expected_rotations.size() == 0)
            begin
                $error("rotated point with no transfer pending: x %0d y %0d z %0d",
                       rotated_x, rotated_y, rotated_z);
                error_count++;
            end
            else
            begin
                want = expected_rotations.pop_front();
                check_field("rotated_x", 32'(want.rx), 32'(rotated_x));
                check_field("rotated_y", 32'(want.ry), 32'(rotated_y));
                check_field("rotated_z", 32'(want.rz), 32'(rotated_z));
                check_field("clipped", 32'(want.clip), 32'(clipped));
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial
    begin
        point_item_t it;
        int          mode;
        int          axis;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        quat_w   = '0;
        quat_x   = '0;
        quat_y   = '0;
        quat_z   = '0;
        point_x  = '0;
        point_y  = '0;
        point_z  = '0;

        // Hand-checked rows: zero quaternion, unit on each axis, ties, extremes
        directed_rows.push_back(dir_row(0, 0, 0, 0, 8388607, -8388608, 8388607,
                                        1'b1, 0, 0, 0, 1'b0));
        directed_rows.push_back(dir_row(-32768, 0, 0, 0, 8388607, -8388608, 12345,
                                        1'b1, 8388607, -8388608, 12345, 1'b0));
        directed_rows.push_back(dir_row(0, -32768, 0, 0, 8388607, 8388607, -8388608,
                                        1'b1, 8388607, -8388607, 8388607, 1'b1));
        directed_rows.push_back(dir_row(0, 0, -32768, 0, -8388608, 5, 7,
                                        1'b1, 8388607, 5, -7, 1'b1));
        directed_rows.push_back(dir_row(0, 0, 0, -32768, 100, -8388608, -8388608,
                                        1'b1, -100, 8388607, -8388608, 1'b1));
        // scale 0.25: halves round toward plus infinity
        directed_rows.push_back(dir_row(16384, 0, 0, 0, 2, -2, 6,
                                        1'b1, 1, 0, 2, 1'b0));
        directed_rows.push_back(dir_row(16384, 0, 0, 0, -6, 3, -3,
                                        1'b1, -1, 1, -1, 1'b0));
        directed_rows.push_back(dir_row(-32768, 0, 0, 0, -8388608, -8388608, -8388608,
                                        1'b1, -8388608, -8388608, -8388608, 1'b0));
        directed_rows.push_back(dir_row(0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0));
        // Predictor-checked rows: non-unit and extreme quaternions, real rotations
        directed_rows.push_back(dir_row(32767, 32767, 32767, 32767,
                                        -8388608, -8388608, -8388608, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(dir_row(-32768, -32768, -32768, -32768,
                                        8388607, 8388607, 8388607, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(dir_row(32767, -32768, 32767, -32768,
                                        8388607, -8388608, 1, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(dir_row(-32768, -32768, 0, 0, 8388607, 1, -1,
                                        1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(dir_row(23170, 0, 0, 23170, 1000, 0, 0,
                                        1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(dir_row(23170, 23170, 0, 0, 0, 1000, -1000,
                                        1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(dir_row(16384, 16384, 16384, 16384,
                                        4000000, -3000000, 2000000, 1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(dir_row(32767, 0, 0, 1, 8388607, 8388607, 8388607,
                                        1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(dir_row(-1, -1, -1, -1, 8388607, -8388608, 8388607,
                                        1'b0, 0, 0, 0, 1'b0));
        directed_rows.push_back(dir_row(21845, -21846, 21845, -21846,
                                        5592405, -5592406, 5592405, 1'b0, 0, 0, 0, 1'b0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            drive_point(directed_rows[i].item);
            if (directed_rows[i].typed)
                expected_rotations.push_back(directed_rows[i].want);
            else
                expected_rotations.push_back(rotate_point(directed_rows[i].item));
        end

        // Random points, three idle profiles
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct   = 17;
                    sink_stall_pct = 53;
                end
                1:
                begin
                    src_idle_pct   = 53;
                    sink_stall_pct = 17;
                end
                default:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < RAND_ITEMS / NUM_PHASES; n++)
            begin
                mode = int'($urandom_range(9));
                it.w  = QUAT_W'($urandom);
                it.x  = QUAT_W'($urandom);
                it.y  = QUAT_W'($urandom);
                it.z  = QUAT_W'($urandom);
                it.px = COORD_W'($urandom);
                it.py = COORD_W'($urandom);
                it.pz = COORD_W'($urandom);
                // quaternion components within +/-23170, full-range points
                if (mode >= 4 && mode <= 6)
                begin
                    it.w = QUAT_W'($urandom_range(46340) - 23170);
                    it.x = QUAT_W'($urandom_range(46340) - 23170);
                    it.y = QUAT_W'($urandom_range(46340) - 23170);
                    it.z = QUAT_W'($urandom_range(46340) - 23170);
                end
                // small points, so most results land inside the range
                if (mode == 7 || mode == 8)
                begin
                    it.px = COORD_W'($urandom_range(8192) - 4096);
                    it.py = COORD_W'($urandom_range(8192) - 4096);
                    it.pz = COORD_W'($urandom_range(8192) - 4096);
                end
                // one dominant component at a full-scale value
                if (mode == 9)
                begin
                    axis = int'($urandom_range(3));
                    it.w = QUAT_W'($urandom_range(4096) - 2048);
                    it.x = QUAT_W'($urandom_range(4096) - 2048);
                    it.y = QUAT_W'($urandom_range(4096) - 2048);
                    it.z = QUAT_W'($urandom_range(4096) - 2048);
                    case (axis)
                        0: it.w = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                        1: it.x = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                        2: it.y = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                        default: it.z = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                    endcase
                end
                drive_point(it);
                expected_rotations.push_back(rotate_point(it));
            end
        end
        in_valid <= 1'b0;

        // Drain, then keep watching to catch stray results
        while (expected_rotations.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_rotations.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
rtl/core/qpr_pkg.sv
rtl/core/qpr_coef.sv
rtl/core/qpr_mac.sv
rtl/core/qpr_round.sv
rtl/core/quaternion_point_rotation.sv
tb/testbench.sv
